FILE: sv/tqm_pkg.sv
package tqm_pkg;

    localparam int ELEMENT_COUNT = 1048576;
    localparam int TEAM_COUNT    = 1024;
    localparam int SLOT_COUNT    = 4096;

    localparam int ELEMENT_W = $clog2(ELEMENT_COUNT);
    localparam int TEAM_W    = $clog2(TEAM_COUNT);
    localparam int SLOT_W    = $clog2(SLOT_COUNT);

    localparam int FRONT_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_ASSIGN = 2'd0,
        OP_ENQ    = 2'd1,
        OP_DEQ    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                  op;
        logic [ELEMENT_W-1:0] element;
        logic [TEAM_W-1:0]    team;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } front_out_t;

endpackage

FILE: sv/tqm_front.sv
module tqm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [tqm_pkg::ELEMENT_W-1:0] s_element,
    input  logic [tqm_pkg::TEAM_W-1:0]    s_team,
    input  logic                          init_done,
    output tqm_pkg::front_out_t           front_out,
    input  logic                          req_pop
);
    import tqm_pkg::*;

    localparam int PW = $clog2(FRONT_DEPTH);

    req_t            q_reg [FRONT_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            push;
    logic            pop;
    req_t            in_req;

    // classify the raw op code into the request type
    always_comb begin
        in_req.element = s_element;
        in_req.team    = s_team;
        case (s_op)
            OP_ASSIGN: in_req.op = OP_ASSIGN;
            OP_ENQ:    in_req.op = OP_ENQ;
            OP_DEQ:    in_req.op = OP_DEQ;
            default:   in_req.op = OP_CLEAR;
        endcase
    end

    assign s_ready = init_done && (cnt_reg != (PW+1)'(FRONT_DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = req_pop && (cnt_reg != '0);

    assign front_out.valid = (cnt_reg != '0);
    assign front_out.req   = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

FILE: sv/tqm_back.sv
module tqm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tqm_pkg::front_out_t           front_out,
    output logic                          req_pop,
    output logic                          init_done,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [tqm_pkg::ELEMENT_W-1:0] m_dequeued
);
    import tqm_pkg::*;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_E1, S_E2, S_D1, S_D2, S_D3, S_DONE
    } state_t;

    // memories
    logic [TEAM_W-1:0]    memb_mem [ELEMENT_COUNT];
    logic                 act_mem  [TEAM_COUNT];
    logic [SLOT_W-1:0]    head_mem [TEAM_COUNT];
    logic [SLOT_W-1:0]    tail_mem [TEAM_COUNT];
    logic [ELEMENT_W-1:0] sv_mem   [SLOT_COUNT];
    logic [SLOT_W-1:0]    sn_mem   [SLOT_COUNT];
    logic [TEAM_W-1:0]    ord_mem  [TEAM_COUNT];

    logic [TEAM_W-1:0]    memb_rd;
    logic                 act_rd;
    logic [SLOT_W-1:0]    head_rd, tail_rd, sn_rd;
    logic [ELEMENT_W-1:0] sv_rd;
    logic [TEAM_W-1:0]    ord_rd;

    logic [ELEMENT_W-1:0] memb_ra;
    logic [TEAM_W-1:0]    team_ra, ord_ra;
    logic [SLOT_W-1:0]    slot_ra;

    logic                 memb_we, act_we, head_we, tail_we, sv_we, sn_we, ord_we;
    logic [ELEMENT_W-1:0] memb_wa;
    logic [TEAM_W-1:0]    memb_wd;
    logic [TEAM_W-1:0]    act_wa, head_wa, tail_wa, ord_wa, ord_wd;
    logic                 act_wd;
    logic [SLOT_W-1:0]    head_wd, tail_wd, sv_wa, sn_wa, sn_wd;
    logic [ELEMENT_W-1:0] sv_wd;

    // control and result registers
    state_t               state_reg, state_next;
    logic                 init_reg, init_next;
    logic [TEAM_W-1:0]    sweep_reg, sweep_next;
    logic [ELEMENT_W-1:0] elem_reg, elem_next;
    logic [TEAM_W-1:0]    team_reg, team_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [SLOT_W-1:0]    tailq_reg, tailq_next;
    logic [SLOT_W-1:0]    fhead_reg, fhead_next;
    logic [SLOT_W:0]      recyc_reg, recyc_next;
    logic [SLOT_W:0]      fresh_reg, fresh_next;
    logic [TEAM_W-1:0]    ord_rp_reg, ord_rp_next;
    logic [TEAM_W-1:0]    ord_wp_reg, ord_wp_next;
    logic [TEAM_W:0]      ord_cnt_reg, ord_cnt_next;
    status_t              res_st_reg, res_st_next;
    logic [ELEMENT_W-1:0] res_dq_reg, res_dq_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [ELEMENT_W-1:0] m_deq_reg, m_deq_next;

    assign init_done  = init_reg;
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_dequeued = m_deq_reg;

    always_comb begin
        state_next    = state_reg;
        init_next     = init_reg;
        sweep_next    = sweep_reg;
        elem_next     = elem_reg;
        team_next     = team_reg;
        slot_next     = slot_reg;
        tailq_next    = tailq_reg;
        fhead_next    = fhead_reg;
        recyc_next    = recyc_reg;
        fresh_next    = fresh_reg;
        ord_rp_next   = ord_rp_reg;
        ord_wp_next   = ord_wp_reg;
        ord_cnt_next  = ord_cnt_reg;
        res_st_next   = res_st_reg;
        res_dq_next   = res_dq_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_deq_next    = m_deq_reg;
        req_pop       = 1'b0;

        memb_ra = front_out.req.element;
        team_ra = '0;
        slot_ra = '0;
        ord_ra  = ord_rp_reg;

        memb_we = 1'b0; memb_wa = front_out.req.element; memb_wd = front_out.req.team;
        act_we  = 1'b0; act_wa  = team_reg; act_wd = 1'b0;
        head_we = 1'b0; head_wa = team_reg; head_wd = slot_reg;
        tail_we = 1'b0; tail_wa = team_reg; tail_wd = slot_reg;
        sv_we   = 1'b0; sv_wa   = slot_reg; sv_wd  = elem_reg;
        sn_we   = 1'b0; sn_wa   = slot_reg; sn_wd  = fhead_reg;
        ord_we  = 1'b0; ord_wa  = ord_wp_reg; ord_wd = team_reg;

        case (state_reg)
            S_SWEEP: begin
                act_we     = 1'b1;
                act_wa     = sweep_reg;
                act_wd     = 1'b0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == TEAM_W'(TEAM_COUNT - 1)) begin
                    init_next  = 1'b1;
                    state_next = init_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (front_out.valid) begin
                    req_pop     = 1'b1;
                    elem_next   = front_out.req.element;
                    res_st_next = ST_OK;
                    res_dq_next = '0;
                    case (front_out.req.op)
                        OP_ASSIGN: begin
                            memb_we    = 1'b1;
                            state_next = S_DONE;
                        end
                        OP_ENQ: begin
                            if (recyc_reg == '0 && fresh_reg == (SLOT_W+1)'(SLOT_COUNT)) begin
                                res_st_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                slot_ra    = fhead_reg;
                                state_next = S_E1;
                            end
                        end
                        OP_DEQ: begin
                            if (ord_cnt_reg == '0) begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_D1;
                            end
                        end
                        default: begin
                            // clear: drop all lists, then sweep the active flags
                            fhead_next   = '0;
                            recyc_next   = '0;
                            fresh_next   = '0;
                            ord_rp_next  = '0;
                            ord_wp_next  = '0;
                            ord_cnt_next = '0;
                            sweep_next   = '0;
                            state_next   = S_SWEEP;
                        end
                    endcase
                end
            end
            S_E1: begin
                team_next = memb_rd;
                team_ra   = memb_rd;
                if (recyc_reg != '0) begin
                    slot_next  = fhead_reg;
                    fhead_next = sn_rd;
                    recyc_next = recyc_reg - 1'b1;
                end else begin
                    slot_next  = fresh_reg[SLOT_W-1:0];
                    fresh_next = fresh_reg + 1'b1;
                end
                state_next = S_E2;
            end
            S_E2: begin
                sv_we   = 1'b1;
                tail_we = 1'b1;
                if (act_rd) begin
                    sn_we = 1'b1;
                    sn_wa = tail_rd;
                    sn_wd = slot_reg;
                end else begin
                    head_we      = 1'b1;
                    act_we       = 1'b1;
                    act_wd       = 1'b1;
                    ord_we       = 1'b1;
                    ord_wp_next  = ord_wp_reg + 1'b1;
                    ord_cnt_next = ord_cnt_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_D1: begin
                team_next  = ord_rd;
                team_ra    = ord_rd;
                state_next = S_D2;
            end
            S_D2: begin
                slot_next  = head_rd;
                tailq_next = tail_rd;
                slot_ra    = head_rd;
                state_next = S_D3;
            end
            S_D3: begin
                res_dq_next = sv_rd;
                if (slot_reg == tailq_reg) begin
                    act_we       = 1'b1;
                    ord_rp_next  = ord_rp_reg + 1'b1;
                    ord_cnt_next = ord_cnt_reg - 1'b1;
                end else begin
                    head_we = 1'b1;
                    head_wd = sn_rd;
                end
                // freed slot goes on the recycle list
                sn_we      = 1'b1;
                fhead_next = slot_reg;
                recyc_next = recyc_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_st_reg;
                    m_deq_next    = res_dq_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP;
            init_reg    <= 1'b0;
            sweep_reg   <= '0;
            fhead_reg   <= '0;
            recyc_reg   <= '0;
            fresh_reg   <= '0;
            ord_rp_reg  <= '0;
            ord_wp_reg  <= '0;
            ord_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            res_st_reg  <= ST_OK;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            sweep_reg   <= sweep_next;
            fhead_reg   <= fhead_next;
            recyc_reg   <= recyc_next;
            fresh_reg   <= fresh_next;
            ord_rp_reg  <= ord_rp_next;
            ord_wp_reg  <= ord_wp_next;
            ord_cnt_reg <= ord_cnt_next;
            m_valid_reg <= m_valid_next;
            res_st_reg  <= res_st_next;
        end
        elem_reg     <= elem_next;
        team_reg     <= team_next;
        slot_reg     <= slot_next;
        tailq_reg    <= tailq_next;
        res_dq_reg   <= res_dq_next;
        m_status_reg <= m_status_next;
        m_deq_reg    <= m_deq_next;
    end

    always_ff @(posedge aclk) begin
        if (memb_we) memb_mem[memb_wa] <= memb_wd;
        memb_rd <= memb_mem[memb_ra];
    end

    always_ff @(posedge aclk) begin
        if (act_we) act_mem[act_wa] <= act_wd;
        act_rd <= act_mem[team_ra];
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[team_ra];
    end

    always_ff @(posedge aclk) begin
        if (tail_we) tail_mem[tail_wa] <= tail_wd;
        tail_rd <= tail_mem[team_ra];
    end

    always_ff @(posedge aclk) begin
        if (sv_we) sv_mem[sv_wa] <= sv_wd;
        sv_rd <= sv_mem[slot_ra];
    end

    always_ff @(posedge aclk) begin
        if (sn_we) sn_mem[sn_wa] <= sn_wd;
        sn_rd <= sn_mem[slot_ra];
    end

    always_ff @(posedge aclk) begin
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        ord_rd <= ord_mem[ord_ra];
    end

endmodule

FILE: sv/team_queue_manager_top.sv
// Team queue manager: requests pass a 2-entry front queue into a sequenced back end.
// The back end handles one request at a time; enqueue and dequeue step through a chain
// of dependent reads through the registered-output pool and team memories.
// Reset (aresetn low, synchronous) starts a sweep of all TEAM_COUNT team
// active flags; s_ready stays low until it ends. Membership survives clear.
module team_queue_manager_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [tqm_pkg::ELEMENT_W-1:0] s_element,
    input  logic [tqm_pkg::TEAM_W-1:0]    s_team,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [tqm_pkg::ELEMENT_W-1:0] m_dequeued
);
    import tqm_pkg::*;

    front_out_t front_out;
    logic       req_pop;
    logic       init_done;

    // front: takes requests, decodes the op, buffers them
    tqm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_element (s_element),
        .s_team    (s_team),
        .init_done (init_done),
        .front_out (front_out),
        .req_pop   (req_pop)
    );

    // back: membership, team lists, slot pool, team order and result register
    tqm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .front_out  (front_out),
        .req_pop    (req_pop),
        .init_done  (init_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_dequeued (m_dequeued)
    );

endmodule
